FILE: design/mipsdec_pkg.sv
// Shared types and decode tables for the MIPS I instruction decoder.
// Used by mipsdec_decode and mips_instruction_decoder_core; depends on nothing.

package mipsdec_pkg;

   localparam int WORD_W     = 32;
   localparam int OPCODE_W   = 6;
   localparam int REG_W      = 5;
   localparam int FUNC_W     = 6;
   localparam int IMM_W      = 16;
   localparam int JIDX_W     = 26;
   localparam int MNEMONIC_W = 7;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 8;

   localparam logic [OPCODE_W-1:0] OP_SPECIAL = 6'h00;
   localparam logic [OPCODE_W-1:0] OP_REGIMM  = 6'h01;

   // Mnemonic classes in alphabetical order; zero marks a reserved encoding.
   typedef enum logic [MNEMONIC_W-1:0] {
      MN_RESERVED = 7'd0,
      MN_ADD, MN_ADDI, MN_ADDIU, MN_ADDU, MN_AND, MN_ANDI, MN_BEQ, MN_BGEZ,
      MN_BGEZAL, MN_BGTZ, MN_BLEZ, MN_BLTZ, MN_BLTZAL, MN_BNE, MN_BREAK,
      MN_COP0, MN_COP1, MN_COP2, MN_COP3, MN_DIV, MN_DIVU, MN_J, MN_JAL,
      MN_JALR, MN_JR, MN_LB, MN_LBU, MN_LH, MN_LHU, MN_LUI, MN_LW,
      MN_LWC1, MN_LWC2, MN_LWC3, MN_LWL, MN_LWR, MN_MFHI, MN_MFLO, MN_MTHI,
      MN_MTLO, MN_MULT, MN_MULTU, MN_NOR, MN_OR, MN_ORI, MN_SB, MN_SH,
      MN_SLL, MN_SLLV, MN_SLT, MN_SLTI, MN_SLTIU, MN_SLTU, MN_SRA, MN_SRAV,
      MN_SRL, MN_SRLV, MN_SUB, MN_SUBU, MN_SW, MN_SWC1, MN_SWC2, MN_SWC3,
      MN_SWL, MN_SWR, MN_SYSCALL, MN_XOR, MN_XORI
   } mnemonic_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] major_opcode;
      logic [REG_W-1:0]    source_reg;
      logic [REG_W-1:0]    target_reg;
      logic [REG_W-1:0]    dest_reg;
      logic [REG_W-1:0]    shift_amount;
      logic [FUNC_W-1:0]   func_code;
      logic [IMM_W-1:0]    imm_field;
      logic [JIDX_W-1:0]   jump_index;
      mnemonic_type        mnemonic_code;
      logic                reserved_flag;
   } decode_type;

   // SPECIAL group, selected by the function field.
   function automatic mnemonic_type special_class(input logic [FUNC_W-1:0] fn);
      mnemonic_type m;
      case (fn)
         6'h00:   m = MN_SLL;
         6'h02:   m = MN_SRL;
         6'h03:   m = MN_SRA;
         6'h04:   m = MN_SLLV;
         6'h06:   m = MN_SRLV;
         6'h07:   m = MN_SRAV;
         6'h08:   m = MN_JR;
         6'h09:   m = MN_JALR;
         6'h0c:   m = MN_SYSCALL;
         6'h0d:   m = MN_BREAK;
         6'h10:   m = MN_MFHI;
         6'h11:   m = MN_MTHI;
         6'h12:   m = MN_MFLO;
         6'h13:   m = MN_MTLO;
         6'h18:   m = MN_MULT;
         6'h19:   m = MN_MULTU;
         6'h1a:   m = MN_DIV;
         6'h1b:   m = MN_DIVU;
         6'h20:   m = MN_ADD;
         6'h21:   m = MN_ADDU;
         6'h22:   m = MN_SUB;
         6'h23:   m = MN_SUBU;
         6'h24:   m = MN_AND;
         6'h25:   m = MN_OR;
         6'h26:   m = MN_XOR;
         6'h27:   m = MN_NOR;
         6'h2a:   m = MN_SLT;
         6'h2b:   m = MN_SLTU;
         default: m = MN_RESERVED;
      endcase
      return m;
   endfunction

   // REGIMM group, selected by the rt field.
   function automatic mnemonic_type regimm_class(input logic [REG_W-1:0] rt);
      mnemonic_type m;
      case (rt)
         5'h00:   m = MN_BLTZ;
         5'h01:   m = MN_BGEZ;
         5'h10:   m = MN_BLTZAL;
         5'h11:   m = MN_BGEZAL;
         default: m = MN_RESERVED;
      endcase
      return m;
   endfunction

   // Primary opcodes. The coprocessor 0 loads and stores stay reserved.
   function automatic mnemonic_type opcode_class(input logic [OPCODE_W-1:0] op);
      mnemonic_type m;
      case (op)
         6'h02:   m = MN_J;
         6'h03:   m = MN_JAL;
         6'h04:   m = MN_BEQ;
         6'h05:   m = MN_BNE;
         6'h06:   m = MN_BLEZ;
         6'h07:   m = MN_BGTZ;
         6'h08:   m = MN_ADDI;
         6'h09:   m = MN_ADDIU;
         6'h0a:   m = MN_SLTI;
         6'h0b:   m = MN_SLTIU;
         6'h0c:   m = MN_ANDI;
         6'h0d:   m = MN_ORI;
         6'h0e:   m = MN_XORI;
         6'h0f:   m = MN_LUI;
         6'h10:   m = MN_COP0;
         6'h11:   m = MN_COP1;
         6'h12:   m = MN_COP2;
         6'h13:   m = MN_COP3;
         6'h20:   m = MN_LB;
         6'h21:   m = MN_LH;
         6'h22:   m = MN_LWL;
         6'h23:   m = MN_LW;
         6'h24:   m = MN_LBU;
         6'h25:   m = MN_LHU;
         6'h26:   m = MN_LWR;
         6'h28:   m = MN_SB;
         6'h29:   m = MN_SH;
         6'h2a:   m = MN_SWL;
         6'h2b:   m = MN_SW;
         6'h2e:   m = MN_SWR;
         6'h31:   m = MN_LWC1;
         6'h32:   m = MN_LWC2;
         6'h33:   m = MN_LWC3;
         6'h39:   m = MN_SWC1;
         6'h3a:   m = MN_SWC2;
         6'h3b:   m = MN_SWC3;
         default: m = MN_RESERVED;
      endcase
      return m;
   endfunction

endpackage

FILE: design/mipsdec_decode.sv
// Combinational field split and mnemonic classification of one instruction word.
// Depends on mipsdec_pkg for the decode tables and the result struct.

module mipsdec_decode (
   input  logic [mipsdec_pkg::WORD_W-1:0] instruction_word,
   output mipsdec_pkg::decode_type        decoded
);
   import mipsdec_pkg::*;

   logic [OPCODE_W-1:0] op;
   mnemonic_type        cls;

   assign op = instruction_word[31:26];

   always_comb begin
      case (op)
         OP_SPECIAL: cls = special_class(instruction_word[5:0]);
         OP_REGIMM:  cls = regimm_class(instruction_word[20:16]);
         default:    cls = opcode_class(op);
      endcase
   end

   // The bit fields pass through whether or not the word is recognized.
   always_comb begin
      decoded.major_opcode  = op;
      decoded.source_reg    = instruction_word[25:21];
      decoded.target_reg    = instruction_word[20:16];
      decoded.dest_reg      = instruction_word[15:11];
      decoded.shift_amount  = instruction_word[10:6];
      decoded.func_code     = instruction_word[5:0];
      decoded.imm_field     = instruction_word[15:0];
      decoded.jump_index    = instruction_word[25:0];
      decoded.mnemonic_code = cls;
      decoded.reserved_flag = (cls == MN_RESERVED);
   end

endmodule

FILE: design/mips_instruction_decoder_core.sv
// MIPS I instruction decoder: input word register, decode logic, result register.
// A word passes through the word register and then the result register before it reaches the rsp side.
// Throughput: one word per cycle; the two register stages each refill in the same
// cycle they drain, so rsp_tready stalls alone limit the rate.
// Reset (synchronous, active high) clears both stage valid flags; no other state.
// Depends on mipsdec_pkg and mipsdec_decode.

module mips_instruction_decoder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] instruction_word
   input  logic [mipsdec_pkg::WORD_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [5:0] major_opcode, [10:6] source_reg, [15:11] target_reg, [20:16] dest_reg,
   // [25:21] shift_amount, [31:26] func_code, [47:32] imm_field,
   // [73:48] jump_index, [79:74] zero
   output logic [mipsdec_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [6:0] mnemonic_code, [7] reserved_flag
   output logic [mipsdec_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import mipsdec_pkg::*;

   logic              word_valid_ff, word_valid_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              rsp_valid_ff, rsp_valid_in;
   decode_type        rsp_ff, rsp_in;
   decode_type        decoded;
   logic              word_ready;
   logic              rsp_ready;

   mipsdec_decode u_decode (
      .instruction_word (word_ff),
      .decoded          (decoded)
   );

   // A stage can load when it is empty or its beat leaves in this cycle.
   assign rsp_ready  = !rsp_valid_ff || rsp_tready;
   assign word_ready = !word_valid_ff || rsp_ready;
   assign req_tready = word_ready;

   always_comb begin
      word_valid_in = word_ready ? req_tvalid : word_valid_ff;
      word_in       = (word_ready && req_tvalid) ? req_tdata : word_ff;
      rsp_valid_in  = rsp_ready ? word_valid_ff : rsp_valid_ff;
      rsp_in        = (rsp_ready && word_valid_ff) ? decoded : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0,
                        rsp_ff.jump_index,
                        rsp_ff.imm_field,
                        rsp_ff.func_code,
                        rsp_ff.shift_amount,
                        rsp_ff.dest_reg,
                        rsp_ff.target_reg,
                        rsp_ff.source_reg,
                        rsp_ff.major_opcode};
   assign rsp_tuser  = {rsp_ff.reserved_flag, rsp_ff.mnemonic_code};

endmodule
